/* hdl/pfrfd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pfrfd_pkg;

  localparam int FLOW_ENTRIES_DEF = 16;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_DROP_TERM     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_REGION_START  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_REGION_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic match_en;
    logic decide_en;
  } dp_cmd_t;

endpackage
`default_nettype wire

/* hdl/pfrfd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfrfd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output pfrfd_pkg::dp_cmd_t     cmd
);

  pfrfd_pkg::ctrl_state_t state_r;
  pfrfd_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfrfd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    busy          = 1'b0;
    cmd.load      = 1'b0;
    cmd.match_en  = 1'b0;
    cmd.decide_en = 1'b0;
    unique case (state_r)
      pfrfd_pkg::S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = pfrfd_pkg::S_MATCH;
        end
      end
      pfrfd_pkg::S_MATCH: begin
        busy         = 1'b1;
        cmd.match_en = 1'b1;
        state_nxt    = pfrfd_pkg::S_DECIDE;
      end
      pfrfd_pkg::S_DECIDE: begin
        cmd.decide_en = 1'b1;
        // next item loads while this one updates the table
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = pfrfd_pkg::S_MATCH;
        end else begin
          state_nxt = pfrfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pfrfd_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/pfrfd_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module pfrfd_dp #(
  parameter int FLOW_ENTRIES = pfrfd_pkg::FLOW_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pfrfd_pkg::dp_cmd_t cmd,
  input  wire logic signed [31:0] drop_term,
  input  wire logic        [30:0] region_start,
  input  wire logic        [30:0] region_length,
  input  wire logic signed [31:0] in_stream,
  input  wire logic signed [31:0] in_session,
  input  wire logic signed [31:0] in_frame_term,
  input  wire logic        [30:0] in_frame_offset,
  input  wire logic        [30:0] in_frame_length,
  output logic                    out_valid,
  output logic                    out_drop
);

  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  // item registers
  logic signed [31:0] stream_r;
  logic signed [31:0] session_r;
  logic signed [31:0] term_r;
  logic        [30:0] offset_r;
  logic        [30:0] length_r;

  // flow table
  logic [FLOW_ENTRIES-1:0] valid_r;
  logic [63:0]             key_r     [FLOW_ENTRIES];
  logic [31:0]             tracked_r [FLOW_ENTRIES];

  // match stage results
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_ok_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             skip_r;

  logic             out_valid_r;
  logic             out_drop_r;

  logic [63:0]      key;
  logic [31:0]      region_end;
  logic             hit_nxt;
  logic [IDX_W-1:0] hit_idx_nxt;
  logic             free_ok_nxt;
  logic [IDX_W-1:0] free_idx_nxt;
  logic             skip_nxt;

  logic [IDX_W-1:0] slot;
  logic [31:0]      offset_w;
  logic [31:0]      frame_end;
  logic [31:0]      tracked_sel;
  logic             usable;
  logic             do_drop;
  logic             tbl_we;
  logic [31:0]      tracked_new;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stream_r  <= in_stream;
      session_r <= in_session;
      term_r    <= in_frame_term;
      offset_r  <= in_frame_offset;
      length_r  <= in_frame_length;
    end
  end

  // parallel key match, lowest index wins
  always_comb begin
    key          = {stream_r, session_r};
    region_end   = {1'b0, region_start} + {1'b0, region_length};
    skip_nxt     = (term_r != drop_term) || ({1'b0, offset_r} >= region_end);
    hit_nxt      = 1'b0;
    hit_idx_nxt  = '0;
    free_ok_nxt  = 1'b0;
    free_idx_nxt = '0;
    for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (key_r[i] == key)) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_ok_nxt  = 1'b1;
        free_idx_nxt = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      hit_r      <= hit_nxt;
      hit_idx_r  <= hit_idx_nxt;
      free_ok_r  <= free_ok_nxt;
      free_idx_r <= free_idx_nxt;
      skip_r     <= skip_nxt;
    end
  end

  // read-modify-write of the selected entry
  always_comb begin
    slot        = hit_r ? hit_idx_r : free_idx_r;
    offset_w    = {1'b0, offset_r};
    frame_end   = offset_w + {1'b0, length_r};
    tracked_sel = hit_r ? tracked_r[hit_idx_r] : offset_w;
    usable      = !skip_r && (hit_r || free_ok_r);
    do_drop     = usable && (tracked_sel <= offset_w) && (frame_end > {1'b0, region_start});
    tbl_we      = cmd.decide_en && usable;
    tracked_new = do_drop ? frame_end : tracked_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.decide_en;
      if (tbl_we) begin
        valid_r[slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      key_r[slot]     <= key;
      tracked_r[slot] <= tracked_new;
    end
    if (cmd.decide_en) begin
      out_drop_r <= do_drop;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drop  = out_drop_r;

endmodule
`default_nettype wire

/* hdl/per_flow_region_frame_dropper_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Per-flow region frame dropper. Pulse start with a frame header while busy is
// low; the drop decision appears on out_drop with out_valid high for exactly
// one cycle, registered after the match and decide states, and cannot be held
// off by the receiver. Each item passes the parallel key match over all flow
// entries and then the read-modify-write of the selected entry; busy is high
// only during the match state, so a new item can be started while the previous
// one is in its read-modify-write. The flow table's valid bits clear at reset,
// so the block is ready right after reset. Registers must be written through
// the APB port only while no item is in flight; the block does not enforce it.
module per_flow_region_frame_dropper_core #(
  parameter int FLOW_ENTRIES = pfrfd_pkg::FLOW_ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [31:0]               in_stream,
  input  wire logic signed [31:0]               in_session,
  input  wire logic signed [31:0]               in_frame_term,
  input  wire logic        [30:0]               in_frame_offset,
  input  wire logic        [30:0]               in_frame_length,
  output logic                                  out_valid,
  output logic                                  out_drop,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [pfrfd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [pfrfd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [pfrfd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                  pready
);

  logic signed [31:0] drop_term_r;
  logic        [30:0] region_start_r;
  logic        [30:0] region_length_r;

  logic                              cfg_we;
  logic [pfrfd_pkg::REG_IDX_W-1:0]   reg_idx;
  pfrfd_pkg::dp_cmd_t                cmd;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[pfrfd_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drop_term_r     <= '0;
      region_start_r  <= '0;
      region_length_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        pfrfd_pkg::REG_DROP_TERM:     drop_term_r     <= pwdata;
        pfrfd_pkg::REG_REGION_START:  region_start_r  <= pwdata[30:0];
        pfrfd_pkg::REG_REGION_LENGTH: region_length_r <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pfrfd_pkg::REG_DROP_TERM:     prdata = drop_term_r;
      pfrfd_pkg::REG_REGION_START:  prdata = {1'b0, region_start_r};
      pfrfd_pkg::REG_REGION_LENGTH: prdata = {1'b0, region_length_r};
      default:                      prdata = '0;
    endcase
  end

  pfrfd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  pfrfd_dp #(
    .FLOW_ENTRIES (FLOW_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .drop_term       (drop_term_r),
    .region_start    (region_start_r),
    .region_length   (region_length_r),
    .in_stream       (in_stream),
    .in_session      (in_session),
    .in_frame_term   (in_frame_term),
    .in_frame_offset (in_frame_offset),
    .in_frame_length (in_frame_length),
    .out_valid       (out_valid),
    .out_drop        (out_drop)
  );

  // every accepted item yields its result after the match and decide states
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted item produced no result");

  // match cycle lasts one cycle
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than the match cycle");

  // no result without a match cycle before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy, 2))
    else $error("result without an accepted item");

endmodule
`default_nettype wire
